>>> rtl/sfr_pkg.sv
// Shared types and constants of the serial frame receiver.
package sfr_pkg;

    localparam int BYTE_W = 8;
    localparam int ID_W = 24;
    localparam int LEN_W = 6;
    localparam int IDX_W = 5;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [15:0] START_MARKER_RST = 16'hFFFF;
    localparam logic [15:0] END_MARKER_RST = 16'hFEFE;

    // register index, taken from paddr[2]
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER = 1'b1;

    typedef struct packed {
        logic [15:0] start_marker;
        logic [15:0] end_marker;
    } markers_t;

    typedef struct packed {
        logic load_id1;
        logic load_id2;
        logic load_id3;
        logic load_len;
        logic load_code;
        logic store_data;
        logic rd_start;
        logic rd_issue;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic start_hi_match;
        logic start_lo_match;
        logic end_hi_match;
        logic end_lo_match;
        logic len_zero;
        logic data_last;
        logic oversize;
        logic rd_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/sfr_regs.sv
// APB register file holding the start and end markers.
module sfr_regs
    import sfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output markers_t              markers
);

    logic [15:0] start_marker_reg;
    logic [15:0] end_marker_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg <= END_MARKER_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_START_MARKER: start_marker_reg <= pwdata[15:0];
                REG_END_MARKER:   end_marker_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_START_MARKER: prdata = {16'h0000, start_marker_reg};
            REG_END_MARKER:   prdata = {16'h0000, end_marker_reg};
            default:          prdata = '0;
        endcase
    end

    assign markers.start_marker = start_marker_reg;
    assign markers.end_marker = end_marker_reg;

endmodule

>>> rtl/sfr_dp.sv
// Datapath: header registers, frame buffer memory and output register.
module sfr_dp
    import sfr_pkg::*;
#(
    parameter int MAX_DATA = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [BYTE_W-1:0]      rx_byte,
    input  markers_t               markers,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int CW = $clog2(MAX_DATA + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_DATA);

    logic [ID_W-1:0]   id_reg;
    logic [7:0]        len_reg;
    logic [7:0]        code_reg;
    logic [7:0]        count_reg;
    logic              oversize_reg;
    logic [CW-1:0]     rd_idx_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] mem [MAX_DATA];

    logic              out_valid_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [7:0]        out_code_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_has_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_last_reg;

    logic [7:0]        rd_idx8;
    logic              has_payload;
    logic              mem_wr;

    assign rd_idx8 = 8'(rd_idx_reg);
    assign has_payload = (len_reg != 8'd0);
    assign mem_wr = cmd.store_data && !oversize_reg && (count_reg < MAX_LEN);

    assign stat.start_hi_match = (rx_byte == markers.start_marker[15:8]);
    assign stat.start_lo_match = (rx_byte == markers.start_marker[7:0]);
    assign stat.end_hi_match = (rx_byte == markers.end_marker[15:8]);
    assign stat.end_lo_match = (rx_byte == markers.end_marker[7:0]);
    assign stat.len_zero = !has_payload;
    assign stat.data_last = ({1'b0, count_reg} + 9'd1) >= {1'b0, len_reg};
    assign stat.oversize = oversize_reg;
    assign stat.rd_last = !has_payload || ((rd_idx8 + 8'd1) == len_reg);
    assign stat.out_free = !out_valid_reg || m_tready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            count_reg <= '0;
            oversize_reg <= 1'b0;
            rd_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_len)
            begin
                len_reg <= rx_byte;
                oversize_reg <= (rx_byte > MAX_LEN);
                count_reg <= '0;
            end
            else if (cmd.store_data)
            begin
                count_reg <= count_reg + 8'd1;
            end

            if (cmd.rd_start)
                rd_idx_reg <= '0;
            else if (cmd.out_load)
                rd_idx_reg <= rd_idx_reg + CW'(1);

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // header and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_id1)
            id_reg[23:16] <= rx_byte;
        if (cmd.load_id2)
            id_reg[15:8] <= rx_byte;
        if (cmd.load_id3)
            id_reg[7:0] <= rx_byte;
        if (cmd.load_code)
            code_reg <= rx_byte;
        if (cmd.out_load)
        begin
            out_id_reg <= id_reg;
            out_code_reg <= code_reg;
            out_len_reg <= len_reg[LEN_W-1:0];
            out_has_reg <= has_payload;
            out_byte_reg <= has_payload ? rd_data_reg : '0;
            out_idx_reg <= has_payload ? rd_idx8[IDX_W-1:0] : '0;
            out_last_reg <= stat.rd_last;
        end
    end

    // frame buffer
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[count_reg[AW-1:0]] <= rx_byte;
        if (cmd.rd_issue)
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {5'b00000, out_idx_reg, out_byte_reg, out_len_reg, out_code_reg, out_id_reg};
    assign m_tuser = out_has_reg;
    assign m_tlast = out_last_reg;

endmodule

>>> rtl/sfr_ctrl.sv
// Controller: frame parser state machine and buffer drain sequencer.
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_START1,
        ST_START2,
        ST_ID1,
        ST_ID2,
        ST_ID3,
        ST_LEN,
        ST_CODE,
        ST_DATA,
        ST_END1,
        ST_END2,
        ST_RD,
        ST_LD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;
    logic   accept;

    assign accept = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_START1:
            begin
                if (accept && stat.start_hi_match)
                    state_next = ST_START2;
            end
            ST_START2:
            begin
                if (accept)
                    state_next = stat.start_lo_match ? ST_ID1 : ST_START1;
            end
            ST_ID1:
            begin
                cmd.load_id1 = accept;
                if (accept)
                    state_next = ST_ID2;
            end
            ST_ID2:
            begin
                cmd.load_id2 = accept;
                if (accept)
                    state_next = ST_ID3;
            end
            ST_ID3:
            begin
                cmd.load_id3 = accept;
                if (accept)
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                cmd.load_len = accept;
                if (accept)
                    state_next = ST_CODE;
            end
            ST_CODE:
            begin
                cmd.load_code = accept;
                if (accept)
                    state_next = stat.len_zero ? ST_END1 : ST_DATA;
            end
            ST_DATA:
            begin
                cmd.store_data = accept;
                if (accept && stat.data_last)
                    state_next = ST_END1;
            end
            ST_END1:
            begin
                if (accept)
                    state_next = stat.end_hi_match ? ST_END2 : ST_START1;
            end
            ST_END2:
            begin
                if (accept)
                begin
                    if (stat.end_lo_match && !stat.oversize)
                    begin
                        cmd.rd_start = 1'b1;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_START1;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next = ST_LD;
            end
            ST_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = stat.rd_last ? ST_START1 : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_START1;
            end
        endcase
        ready_next = (state_next != ST_RD) && (state_next != ST_LD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START1;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

>>> rtl/serial_frame_receiver.sv
// Top level of the serial frame receiver.
//
//  port group  | dir | payload
//  s_t*        | in  | s_tdata[7:0] rx_byte
//  m_t*        | out | m_tdata: sender_id, msg_code, payload_length, payload_byte,
//              |     |   payload_index; m_tuser has_payload; m_tlast last_of_frame
//  APB         | in  | 0x0 start_marker, 0x4 end_marker
//
// One received byte is taken per cycle while a frame is parsed.
// A good frame is drained from the buffer one result at a time, each by a memory
// read, then an output register load, during which s_tready is low.
// The output register holds a result until taken; m_tready low stalls the drain.
// Reset is asynchronous, active low; the buffer needs no clearing pass.
module serial_frame_receiver
    import sfr_pkg::*;
#(
    parameter int MAX_DATA = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [23:0] sender_id, [31:24] msg_code, [37:32] payload_length,
    // [45:38] payload_byte, [50:46] payload_index, [55:51] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,   // [0] has_payload
    output logic                   m_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    markers_t markers;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    sfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .markers (markers)
    );

    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfr_dp #(
        .MAX_DATA (MAX_DATA)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (s_tdata),
        .markers  (markers),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/sfr_checker.sv
// Port-level checks on the serial frame receiver, bound to the top level.
module sfr_checker
    import sfr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser,
    input logic                   m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
        && $stable(m_tuser))
        else $error("stalled result changed");

    // empty frame gives a single, last result with zero length
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[37:32] == 6'd0)
        && (m_tdata[45:38] == 8'd0) && (m_tdata[50:46] == 5'd0))
        else $error("bad empty-frame result");

    // last data result sits at the final index
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && m_tlast |-> (6'(m_tdata[50:46]) + 6'd1) == m_tdata[37:32])
        else $error("last flag at wrong index");

    // a non-last data result is followed within the same frame by index + 1
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser && !m_tlast ##1 m_tvalid |->
        m_tdata[50:46] == $past(m_tdata[50:46]) + 5'd1)
        else $error("payload index did not advance");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/testbench.sv
// Self-checking testbench for the serial frame receiver: byte stream in, framed results out.
module testbench;
    import sfr_pkg::*;

    localparam int MAX_DATA = 32;
    localparam int SEG_ITEMS = 44;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [CFG_ADDR_W-1:0] ADDR_START = {REG_START_MARKER, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_END = {REG_END_MARKER, 2'b00};

    typedef enum logic [3:0] {
        HUNT_START1, HUNT_START2, GET_ID1, GET_ID2, GET_ID3,
        GET_LEN, GET_CODE, GET_DATA, CHK_END1, CHK_END2
    } parse_state_t;

    typedef struct packed {
        logic [ID_W-1:0]  sender_id;
        logic [7:0]       msg_code;
        logic [LEN_W-1:0] payload_length;
        logic             has_payload;
        logic [7:0]       payload_byte;
        logic [IDX_W-1:0] payload_index;
        logic             last_of_frame;
    } rx_result_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       checked;
        rx_result_t want;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    int send_idle_pct = 11;
    int recv_idle_pct = 49;
    int errors = 0;

    // frame parser copy, kept in step with accepted bytes
    logic [15:0]  start_mk = START_MARKER_RST;
    logic [15:0]  end_mk = END_MARKER_RST;
    parse_state_t pstate = HUNT_START1;
    logic [23:0]  frm_id = '0;
    logic [7:0]   frm_len = '0;
    logic [7:0]   frm_code = '0;
    logic [7:0]   data_cnt = '0;
    logic         too_long = 1'b0;
    logic [7:0]   frame_buf [MAX_DATA];

    rx_result_t pending_results[$];

    serial_frame_receiver #(.MAX_DATA(MAX_DATA)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic parse_byte(input logic [7:0] b, ref rx_result_t res[$]);
        case (pstate)
            HUNT_START1:
                if (b == start_mk[15:8])
                    pstate = HUNT_START2;
            HUNT_START2:
                pstate = (b == start_mk[7:0]) ? GET_ID1 : HUNT_START1;
            GET_ID1:
            begin
                frm_id = {b, 16'h0000};
                pstate = GET_ID2;
            end
            GET_ID2:
            begin
                frm_id = {frm_id[23:16], b, 8'h00};
                pstate = GET_ID3;
            end
            GET_ID3:
            begin
                frm_id[7:0] = b;
                pstate = GET_LEN;
            end
            GET_LEN:
            begin
                frm_len = b;
                too_long = (b > MAX_DATA);
                data_cnt = '0;
                pstate = GET_CODE;
            end
            GET_CODE:
            begin
                frm_code = b;
                pstate = (frm_len == 0) ? CHK_END1 : GET_DATA;
            end
            GET_DATA:
            begin
                if (!too_long && data_cnt < MAX_DATA)
                    frame_buf[data_cnt] = b;
                data_cnt = data_cnt + 8'd1;
                if (data_cnt >= frm_len)
                    pstate = CHK_END1;
            end
            CHK_END1:
                pstate = (b == end_mk[15:8]) ? CHK_END2 : HUNT_START1;
            CHK_END2:
            begin
                pstate = HUNT_START1;
                if (b == end_mk[7:0] && !too_long)
                begin
                    if (frm_len == 0)
                        res.push_back('{frm_id, frm_code, 6'd0, 1'b0, 8'h00, 5'd0, 1'b1});
                    else
                        for (int k = 0; k < frm_len; k++)
                            res.push_back('{frm_id, frm_code, frm_len[5:0], 1'b1,
                                            frame_buf[k], 5'(k), (k + 1 == frm_len)});
                end
            end
            default:
                pstate = HUNT_START1;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // output side: random backpressure, every transaction checked in order
    always @(posedge clk)
    begin
        rx_result_t got;
        rx_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[23:0], m_tdata[31:24], m_tdata[37:32], m_tuser,
                    m_tdata[45:38], m_tdata[50:46], m_tlast};
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("sender_id", want.sender_id, got.sender_id);
                check_field("msg_code", want.msg_code, got.msg_code);
                check_field("payload_length", want.payload_length, got.payload_length);
                check_field("has_payload", want.has_payload, got.has_payload);
                check_field("payload_byte", want.payload_byte, got.payload_byte);
                check_field("payload_index", want.payload_index, got.payload_index);
                check_field("last_of_frame", want.last_of_frame, got.last_of_frame);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending, let every due result drain, then give the block time to settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one APB transaction; a read compares prdata with data
    task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wr ? data : '0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (!wr && prdata !== data)
        begin
            errors++;
            $display("%0t: register 0x%0h mismatch, expected 0x%0h, got 0x%0h",
                     $time, addr, data, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        dir_row_t   dir_rows [30];
        rx_result_t step_res[$];
        logic [7:0] burst[$];
        logic [15:0] seg_start [6];
        logic [15:0] seg_end [6];
        logic [7:0] flen;
        int         roll;
        int         pick;
        int         sent;

        // hunt misses on both start bytes, an empty frame, a one-byte frame at the
        // field extremes, then a frame whose first end byte is wrong
        dir_rows = '{
            '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h12, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'hFE, 1'b0, '0},
            '{8'hFE, 1'b1, '{24'h000000, 8'hFF, 6'd0, 1'b0, 8'h00, 5'd0, 1'b1}},
            '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h01, 1'b0, '0},
            '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFE, 1'b0, '0},
            '{8'hFE, 1'b1, '{24'hFFFFFF, 8'h00, 6'd1, 1'b1, 8'hFF, 5'd0, 1'b1}},
            '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h5A, 1'b0, '0},
            '{8'h5A, 1'b0, '0}, '{8'h5A, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h77, 1'b0, '0}, '{8'h00, 1'b0, '0}
        };
        seg_start = '{START_MARKER_RST, 16'h0000, 16'hFFFF, 16'($urandom), 16'h00FF,
                      START_MARKER_RST};
        seg_end = '{END_MARKER_RST, 16'h0000, 16'hFFFF, 16'($urandom), 16'hFF00,
                    END_MARKER_RST};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, ADDR_START, {16'h0000, START_MARKER_RST});
        apb_access(1'b0, ADDR_END, {16'h0000, END_MARKER_RST});

        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].rx);
            step_res.delete();
            parse_byte(dir_rows[i].rx, step_res);
            if (dir_rows[i].checked)
                pending_results.push_back(dir_rows[i].want);
            else
                pending_results = {pending_results, step_res};
        end

        for (int seg = 0; seg < 6; seg++)
        begin
            send_idle_pct = (seg < 2) ? 11 : (seg < 4) ? 49 : 0;
            recv_idle_pct = (seg < 2) ? 49 : (seg < 4) ? 11 : 0;
            if (seg != 0)
            begin
                wait_drained();
                apb_access(1'b1, ADDR_START, {16'h0000, seg_start[seg]});
                apb_access(1'b1, ADDR_END, {16'h0000, seg_end[seg]});
                start_mk = seg_start[seg];
                end_mk = seg_end[seg];
                apb_access(1'b0, ADDR_START, {16'h0000, start_mk});
                apb_access(1'b0, ADDR_END, {16'h0000, end_mk});
            end

            sent = 0;
            while (sent < SEG_ITEMS)
            begin
                burst.delete();
                roll = $urandom_range(99);
                if (roll < 8)
                    burst.push_back(8'($urandom));
                else
                begin
                    // mostly short frames, some longer ones up to full size, a few oversize
                    pick = $urandom_range(99);
                    if (pick < 65)
                        flen = 8'($urandom_range(8));
                    else if (pick < 88)
                        flen = ($urandom_range(2) == 0) ? 8'd32 : 8'($urandom_range(32, 9));
                    else if (pick < 97)
                        flen = 8'($urandom_range(40, 33));
                    else
                        flen = 8'($urandom_range(255, 64));
                    burst = {start_mk[15:8], start_mk[7:0], 8'($urandom), 8'($urandom),
                             8'($urandom), flen, 8'($urandom)};
                    repeat (flen) burst.push_back(8'($urandom));
                    burst.push_back(end_mk[15:8]);
                    burst.push_back(end_mk[7:0]);
                    if (roll < 14)
                        burst[1] ^= 8'($urandom_range(255, 1));
                    else if (roll < 22)
                        burst[burst.size() - 2 + $urandom_range(1)] ^= 8'($urandom_range(255, 1));
                end
                foreach (burst[i])
                begin
                    send_byte(burst[i]);
                    parse_byte(burst[i], pending_results);
                end
                sent += burst.size();
                if (seg == 3 && $urandom_range(9) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/sfr_pkg.sv
rtl/sfr_regs.sv
rtl/sfr_dp.sv
rtl/sfr_ctrl.sv
rtl/serial_frame_receiver.sv
rtl/sfr_checker.sv
tb/testbench.sv
